// ===== design/sva_pkg.sv =====
// ----------------------------------------------------------------------------
// Versioned array package
// Field widths, operation and status codes, controller states and the
// command and status structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package sva_pkg;

    localparam int FUNC_W    = 2;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 30;
    localparam int SNAP_ID_W = 16;
    localparam int RESULT_W  = 30;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 11;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SNAP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GET  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_SAT   = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_WAIT,
        ST_CNT_LOAD,
        ST_HIST_WAIT,
        ST_HIST_CHK,
        ST_APPEND,
        ST_DONE
    } sva_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic load_cnt;
        logic ptr_step;
        logic k_step;
        logic wr_over;
        logic wr_app;
        logic set_full;
        logic take_value;
        logic out_load;
    } sva_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic new_search;
        logic cnt_zero;
        logic is_set;
        logic key_eq;
        logic key_le;
        logic k_one;
        logic cnt_full;
        logic out_free;
    } sva_sts_t;

endpackage

// ===== design/sva_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one operation word into the block.
// ----------------------------------------------------------------------------
interface sva_req_if;

    logic                            valid;
    logic                            ready;
    logic [sva_pkg::FUNC_W-1:0]      func;
    logic [sva_pkg::INDEX_W-1:0]     index;
    logic [sva_pkg::VALUE_W-1:0]     value;
    logic [sva_pkg::SNAP_ID_W-1:0]   snap_id;

    modport source (
        output valid,
        output func,
        output index,
        output value,
        output snap_id,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  index,
        input  value,
        input  snap_id,
        output ready
    );

endinterface

// ===== design/sva_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result word out of the block.
// ----------------------------------------------------------------------------
interface sva_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [sva_pkg::RESULT_W-1:0]   result;
    logic [sva_pkg::STATUS_W-1:0]   status;

    modport source (
        output valid,
        output result,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  result,
        input  status,
        output ready
    );

endinterface

// ===== design/sva_ctrl.sv =====
// ----------------------------------------------------------------------------
// Versioned array controller
// Sequences the clearing pass, the count lookup, the history search and
// the update for each accepted word.
// ----------------------------------------------------------------------------
module sva_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sva_pkg::sva_sts_t sts,
    output sva_pkg::sva_cmd_t cmd
);

    sva_pkg::sva_state_t state_reg;
    sva_pkg::sva_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sva_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sva_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = sva_pkg::ST_IDLE;
                end
            end
            sva_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.new_search ? sva_pkg::ST_CNT_WAIT : sva_pkg::ST_DONE;
                end
            end
            sva_pkg::ST_CNT_WAIT:
            begin
                state_next = sva_pkg::ST_CNT_LOAD;
            end
            sva_pkg::ST_CNT_LOAD:
            begin
                cmd.load_cnt = 1'b1;
                if (sts.cnt_zero)
                begin
                    state_next = sts.is_set ? sva_pkg::ST_APPEND : sva_pkg::ST_DONE;
                end
                else
                begin
                    state_next = sva_pkg::ST_HIST_WAIT;
                end
            end
            sva_pkg::ST_HIST_WAIT:
            begin
                cmd.ptr_step = 1'b1;
                state_next   = sva_pkg::ST_HIST_CHK;
            end
            sva_pkg::ST_HIST_CHK:
            begin
                if (sts.is_set)
                begin
                    if (sts.key_eq)
                    begin
                        cmd.wr_over = 1'b1;
                        state_next  = sva_pkg::ST_DONE;
                    end
                    else if (sts.cnt_full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = sva_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = sva_pkg::ST_APPEND;
                    end
                end
                else if (sts.key_le)
                begin
                    cmd.take_value = 1'b1;
                    state_next     = sva_pkg::ST_DONE;
                end
                else if (sts.k_one)
                begin
                    state_next = sva_pkg::ST_DONE;
                end
                else
                begin
                    cmd.k_step = 1'b1;
                end
            end
            sva_pkg::ST_APPEND:
            begin
                cmd.wr_app = 1'b1;
                state_next = sva_pkg::ST_DONE;
            end
            sva_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sva_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== design/sva_datapath.sv =====
// ----------------------------------------------------------------------------
// Versioned array datapath
// Count and history memories, the snapshot counter, the length register,
// the search compare and the output register.
// ----------------------------------------------------------------------------
module sva_datapath #(
    parameter int NUM_ELEMENTS  = 1024,
    parameter int HISTORY_DEPTH = 16,
    parameter int VALUE_BITS    = 30,
    parameter int SNAP_BITS     = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sva_pkg::sva_cmd_t               cmd,
    output sva_pkg::sva_sts_t               sts,
    input  logic [sva_pkg::FUNC_W-1:0]      func,
    input  logic [sva_pkg::INDEX_W-1:0]     index,
    input  logic [sva_pkg::VALUE_W-1:0]     value,
    input  logic [sva_pkg::SNAP_ID_W-1:0]   snap_id,
    input  logic                            cfg_we,
    input  logic [sva_pkg::LEN_W-1:0]       cfg_wdata,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sva_pkg::RESULT_W-1:0]    out_result,
    output logic [sva_pkg::STATUS_W-1:0]    out_status
);

    localparam int EW   = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int KW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int HW   = SNAP_BITS + VALUE_BITS;
    localparam int HD   = NUM_ELEMENTS * (1 << KW);
    localparam int CMPW = (SNAP_BITS > sva_pkg::SNAP_ID_W) ? SNAP_BITS : sva_pkg::SNAP_ID_W;

    localparam logic [CW-1:0] DEPTH_C   = CW'(HISTORY_DEPTH);
    localparam logic [CW-1:0] ONE_C     = CW'(1);
    localparam logic [EW-1:0] LAST_ELEM = EW'(NUM_ELEMENTS - 1);

    logic [CW-1:0] cnt_mem  [NUM_ELEMENTS];
    logic [HW-1:0] hist_mem [HD];

    logic                         out_valid_reg;
    logic [sva_pkg::RESULT_W-1:0] out_result_reg;
    logic [sva_pkg::STATUS_W-1:0] out_status_reg;
    logic [EW-1:0]                clr_ptr_reg;
    logic [SNAP_BITS-1:0]         snap_cnt_reg;
    logic [sva_pkg::LEN_W-1:0]    len_reg;

    logic [sva_pkg::FUNC_W-1:0]   func_reg;
    logic [EW-1:0]                elem_reg;
    logic [VALUE_BITS-1:0]        val_reg;
    logic [CMPW-1:0]              sid_reg;
    logic [CW-1:0]                cnt_reg;
    logic [KW-1:0]                ptr_reg;
    logic [sva_pkg::RESULT_W-1:0] res_reg;
    logic [sva_pkg::STATUS_W-1:0] sts_reg;
    logic [CW-1:0]                cnt_rd_reg;
    logic [HW-1:0]                hist_rd_reg;

    logic [31:0]           idx_ext;
    logic                  in_range;
    logic                  snap_sat;
    logic [CW-1:0]         cnt_val;
    logic [CW-1:0]         cnt_m1;
    logic [SNAP_BITS-1:0]  rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  cnt_we;
    logic [EW-1:0]         cnt_waddr;
    logic [CW-1:0]         cnt_wdata;
    logic                  hist_we;
    logic [KW-1:0]         hist_wslot;

    assign idx_ext  = 32'(index);
    assign in_range = (idx_ext < 32'(len_reg)) && (idx_ext < 32'(NUM_ELEMENTS));
    assign snap_sat = (snap_cnt_reg == {SNAP_BITS{1'b1}});
    assign cnt_val  = (cnt_rd_reg > DEPTH_C) ? DEPTH_C : cnt_rd_reg;
    assign cnt_m1   = cnt_reg - ONE_C;
    assign rd_key   = hist_rd_reg[HW-1 -: SNAP_BITS];
    assign rd_val   = hist_rd_reg[VALUE_BITS-1:0];

    always_comb
    begin
        cnt_we    = cmd.clear || cmd.wr_app;
        cnt_waddr = cmd.clear ? clr_ptr_reg : elem_reg;
        cnt_wdata = cmd.clear ? '0 : (cnt_reg + ONE_C);
        hist_we    = cmd.wr_over || cmd.wr_app;
        hist_wslot = cmd.wr_over ? cnt_m1[KW-1:0] : cnt_reg[KW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[elem_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[{elem_reg, hist_wslot}] <= {snap_cnt_reg, val_reg};
        end
        hist_rd_reg <= hist_mem[{elem_reg, ptr_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_ptr_reg   <= '0;
            snap_cnt_reg  <= '0;
            len_reg       <= sva_pkg::LEN_RESET;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clear)
            begin
                clr_ptr_reg <= clr_ptr_reg + EW'(1);
            end
            if (cmd.accept && (func == sva_pkg::FUNC_SNAP) && !snap_sat)
            begin
                snap_cnt_reg <= snap_cnt_reg + SNAP_BITS'(1);
            end
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            elem_reg <= idx_ext[EW-1:0];
            val_reg  <= VALUE_BITS'(value);
            sid_reg  <= CMPW'(snap_id);
            case (func)
                sva_pkg::FUNC_SET, sva_pkg::FUNC_GET:
                begin
                    res_reg <= '0;
                    sts_reg <= in_range ? sva_pkg::STS_OK : sva_pkg::STS_RANGE;
                end
                sva_pkg::FUNC_SNAP:
                begin
                    res_reg <= sva_pkg::RESULT_W'(snap_cnt_reg);
                    sts_reg <= snap_sat ? sva_pkg::STS_SAT : sva_pkg::STS_OK;
                end
                default:
                begin
                    res_reg <= '0;
                    sts_reg <= sva_pkg::STS_OK;
                end
            endcase
        end
        if (cmd.load_cnt)
        begin
            cnt_reg <= cnt_val;
            ptr_reg <= KW'(cnt_val - ONE_C);
        end
        if (cmd.ptr_step)
        begin
            ptr_reg <= ptr_reg - KW'(1);
        end
        if (cmd.k_step)
        begin
            cnt_reg <= cnt_m1;
            ptr_reg <= ptr_reg - KW'(1);
        end
        if (cmd.set_full)
        begin
            sts_reg <= sva_pkg::STS_FULL;
        end
        if (cmd.take_value)
        begin
            res_reg <= sva_pkg::RESULT_W'(rd_val);
        end
        if (cmd.out_load)
        begin
            out_result_reg <= res_reg;
            out_status_reg <= sts_reg;
        end
    end

    always_comb
    begin
        sts.clr_last   = (clr_ptr_reg == LAST_ELEM);
        sts.new_search = ((func == sva_pkg::FUNC_SET) || (func == sva_pkg::FUNC_GET)) && in_range;
        sts.cnt_zero   = (cnt_val == '0);
        sts.is_set     = (func_reg == sva_pkg::FUNC_SET);
        sts.key_eq     = (rd_key == snap_cnt_reg);
        sts.key_le     = (CMPW'(rd_key) <= sid_reg);
        sts.k_one      = (cnt_reg == ONE_C);
        sts.cnt_full   = (cnt_reg == DEPTH_C);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_status = out_status_reg;

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_cnt |=> (cnt_reg <= DEPTH_C))
        else $error("Loaded history count exceeds the depth.");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_app |-> (cnt_reg < DEPTH_C))
        else $error("Append issued on a full history.");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("Output register loaded while a word is still pending.");

    a_snap_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (snap_cnt_reg >= $past(snap_cnt_reg)))
        else $error("Snapshot counter moved backward.");

endmodule

// ===== design/snapshot_versioned_array.sv =====
// ----------------------------------------------------------------------------
// Snapshot versioned array
// An array of NUM_ELEMENTS elements, each with up to HISTORY_DEPTH stored
// (snapshot, value) entries. After reset the block clears the per-element counts
// one element after another and accepts no word until that pass ends.
// One word is processed at a time. A snap, an unused code and an out-of-range
// set or get go straight from acceptance to loading the result register. An
// in-range set or get first reads the element's count. A get with no history
// then loads its result; otherwise it examines one history entry per cycle from
// the newest, up to HISTORY_DEPTH entries, until one is no newer than its snap_id.
// A set checks the newest entry, if any, then overwrites it, appends or reports full.
// The result register loads only once the previous result has left it, so a
// stalled output adds its wait. The next word is accepted in the cycle after
// the result is registered, while that result may still wait in the output
// register.
// ----------------------------------------------------------------------------
module snapshot_versioned_array #(
    parameter int NUM_ELEMENTS  = 1024,
    parameter int HISTORY_DEPTH = 16,
    parameter int VALUE_BITS    = 30,
    parameter int SNAP_BITS     = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    sva_req_if.sink                      req,
    sva_rsp_if.source                    rsp,
    input  logic                         cfg_we,
    input  logic [sva_pkg::LEN_W-1:0]    cfg_wdata
);

    sva_pkg::sva_cmd_t cmd;
    sva_pkg::sva_sts_t sts;
    logic              in_ready;

    sva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sva_datapath #(
        .NUM_ELEMENTS  (NUM_ELEMENTS),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .VALUE_BITS    (VALUE_BITS),
        .SNAP_BITS     (SNAP_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .func       (req.func),
        .index      (req.index),
        .value      (req.value),
        .snap_id    (req.snap_id),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_result (rsp.result),
        .out_status (rsp.status)
    );

    assign req.ready = in_ready;

endmodule

// ===== dv/snapshot_versioned_array_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Snapshot versioned array testbench
// Drives set, snap, get and unused operation words into the array and checks
// every response word against a predictor that keeps its own copy of the
// per-element history, the snapshot counter and the length register.
// Directed tests cover basic operations, range limits and a full history.
// Random traffic runs under varied idling on both channels and several
// length settings.
// ----------------------------------------------------------------------------
module snapshot_versioned_array_test;

    localparam int NUM_ELEM    = 1024;
    localparam int HIST_DEPTH  = 16;
    localparam int QUIET_LIMIT = 5000;

    localparam logic [sva_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [sva_pkg::RESULT_W-1:0] result;
        logic [sva_pkg::STATUS_W-1:0] status;
    } answer_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [sva_pkg::LEN_W-1:0]     cfg_wdata;

    sva_req_if req_bus ();
    sva_rsp_if rsp_bus ();

    logic [sva_pkg::VALUE_W-1:0]   hist_value [NUM_ELEM][HIST_DEPTH];
    logic [sva_pkg::SNAP_ID_W-1:0] hist_key   [NUM_ELEM][HIST_DEPTH];
    int unsigned                   hist_count [NUM_ELEM];
    logic [sva_pkg::SNAP_ID_W-1:0] model_snap;
    logic [sva_pkg::LEN_W-1:0]     length_reg;

    answer_t awaited_answers [$];
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    int      src_idle_pct = 16;
    int      snk_idle_pct = 60;

    snapshot_versioned_array #(
        .NUM_ELEMENTS  (NUM_ELEM),
        .HISTORY_DEPTH (HIST_DEPTH),
        .VALUE_BITS    (sva_pkg::VALUE_W),
        .SNAP_BITS     (sva_pkg::SNAP_ID_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic answer_t apply_operation(input logic [sva_pkg::FUNC_W-1:0] op,
                                                input logic [sva_pkg::INDEX_W-1:0] idx,
                                                input logic [sva_pkg::VALUE_W-1:0] val,
                                                input logic [sva_pkg::SNAP_ID_W-1:0] sid);
        answer_t     ans;
        int unsigned active;
        int unsigned cnt;
        ans = '{result: '0, status: sva_pkg::STS_OK};
        active = (length_reg < NUM_ELEM) ? length_reg : NUM_ELEM;
        if (op == sva_pkg::FUNC_SET || op == sva_pkg::FUNC_GET)
        begin
            cnt = hist_count[idx];
            if (idx >= active)
            begin
                ans.status = sva_pkg::STS_RANGE;
            end
            else if (op == sva_pkg::FUNC_SET)
            begin
                if (cnt > 0 && hist_key[idx][cnt-1] == model_snap)
                begin
                    hist_value[idx][cnt-1] = val;
                end
                else if (cnt >= HIST_DEPTH)
                begin
                    ans.status = sva_pkg::STS_FULL;
                end
                else
                begin
                    hist_key[idx][cnt] = model_snap;
                    hist_value[idx][cnt] = val;
                    hist_count[idx] = cnt + 1;
                end
            end
            else
            begin
                for (int k = cnt; k > 0; k--)
                begin
                    if (hist_key[idx][k-1] <= sid)
                    begin
                        ans.result = hist_value[idx][k-1];
                        break;
                    end
                end
            end
        end
        else if (op == sva_pkg::FUNC_SNAP)
        begin
            ans.result = sva_pkg::RESULT_W'(model_snap);
            if (model_snap == '1)
                ans.status = sva_pkg::STS_SAT;
            else
                model_snap = model_snap + 1'b1;
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // The request word stays valid after acceptance; the next call or
    // release_request decides what happens in that same cycle.
    task automatic send_word(input logic [sva_pkg::FUNC_W-1:0] op,
                             input logic [sva_pkg::INDEX_W-1:0] idx,
                             input logic [sva_pkg::VALUE_W-1:0] val,
                             input logic [sva_pkg::SNAP_ID_W-1:0] sid);
        answer_t ans;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.func    <= op;
        req_bus.index   <= idx;
        req_bus.value   <= val;
        req_bus.snap_id <= sid;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        ans = apply_operation(op, idx, val, sid);
        awaited_answers = {awaited_answers, ans};
    endtask

    task automatic release_request();
        req_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        release_request();
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(input logic [sva_pkg::LEN_W-1:0] len);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
        length_reg = len;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : rsp_monitor
        answer_t want;
        if (rst_n === 1'b1)
        begin
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            begin
                if (awaited_answers.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected response result=%0h status=%0d",
                                              rsp_bus.result, rsp_bus.status));
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (rsp_bus.result !== want.result)
                        report_mismatch($sformatf("result %0h, expected %0h",
                                                  rsp_bus.result, want.result));
                    if (rsp_bus.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_bus.status, want.status));
                end
            end
        end
        rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic test_basic_ops();
        send_word(sva_pkg::FUNC_GET, 10'd0, 30'd0, 16'd0);
        send_word(sva_pkg::FUNC_SET, 10'd0, '1, 16'd0);
        send_word(sva_pkg::FUNC_GET, 10'd0, 30'd0, 16'd0);
        send_word(sva_pkg::FUNC_SET, 10'd0, 30'h2AAA_AAAA, 16'h0000);
        send_word(sva_pkg::FUNC_SNAP, 10'd0, 30'd0, 16'd0);
        send_word(sva_pkg::FUNC_SET, 10'd0, 30'h1555_5555, 16'hFFFF);
        send_word(sva_pkg::FUNC_GET, 10'd0, 30'd0, 16'd0);
        send_word(sva_pkg::FUNC_GET, 10'd0, 30'd0, 16'hFFFF);
        send_word(sva_pkg::FUNC_SET, 10'd1023, 30'd0, 16'd0);
        send_word(sva_pkg::FUNC_GET, 10'd1023, '1, 16'd1);
        send_word(FUNC_UNUSED, 10'd1023, '1, 16'hFFFF);
        send_word(sva_pkg::FUNC_SNAP, '1, '1, '1);
        send_word(sva_pkg::FUNC_GET, 10'd512, 30'd0, 16'h5555);
    endtask

    task automatic test_length_limits();
        write_length(11'd0);
        send_word(sva_pkg::FUNC_SET, 10'd0, 30'd5, 16'd0);
        send_word(sva_pkg::FUNC_GET, 10'd0, 30'd0, 16'hFFFF);
        write_length(11'd1);
        send_word(sva_pkg::FUNC_GET, 10'd0, 30'd0, 16'hFFFF);
        send_word(sva_pkg::FUNC_SET, 10'd1, 30'd7, 16'd0);
        write_length(11'd2047);
        send_word(sva_pkg::FUNC_SET, 10'd1023, 30'h3000_0001, 16'd0);
        send_word(sva_pkg::FUNC_GET, 10'd1023, 30'd0, 16'hFFFF);
        write_length(11'd1024);
        send_word(sva_pkg::FUNC_GET, 10'd1023, 30'd0, 16'hFFFF);
    endtask

    task automatic test_history_full();
        logic [sva_pkg::SNAP_ID_W-1:0] first_key;
        first_key = model_snap;
        for (int i = 0; i < HIST_DEPTH - 1; i++)
        begin
            send_word(sva_pkg::FUNC_SET, 10'd2, sva_pkg::VALUE_W'($urandom()), 16'd0);
            send_word(sva_pkg::FUNC_SNAP, 10'd0, 30'd0, 16'd0);
        end
        send_word(sva_pkg::FUNC_SET, 10'd2, 30'h0ABC_DEF0, 16'd0);
        send_word(sva_pkg::FUNC_SET, 10'd2, 30'h0123_4567, 16'd0);
        send_word(sva_pkg::FUNC_SNAP, 10'd0, 30'd0, 16'd0);
        send_word(sva_pkg::FUNC_SET, 10'd2, 30'h3FFF_0000, 16'd0);
        send_word(sva_pkg::FUNC_GET, 10'd2, 30'd0, first_key + 16'd7);
        send_word(sva_pkg::FUNC_GET, 10'd2, 30'd0, first_key - 16'd1);
        send_word(sva_pkg::FUNC_GET, 10'd2, 30'd0, 16'hFFFF);
    endtask

    task automatic test_random_traffic(input int count, input int src_pct,
                                       input int snk_pct,
                                       input logic [sva_pkg::LEN_W-1:0] len);
        logic [sva_pkg::FUNC_W-1:0]    op;
        logic [sva_pkg::INDEX_W-1:0]   idx;
        logic [sva_pkg::VALUE_W-1:0]   val;
        logic [sva_pkg::SNAP_ID_W-1:0] sid;
        int                            r;
        write_length(len);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            op = (r < 40) ? sva_pkg::FUNC_SET :
                 (r < 58) ? sva_pkg::FUNC_SNAP :
                 (r < 95) ? sva_pkg::FUNC_GET : FUNC_UNUSED;
            r = $urandom_range(99);
            if (r < 65)
                idx = sva_pkg::INDEX_W'($urandom_range(7));
            else if (r < 75)
                idx = sva_pkg::INDEX_W'(len - $urandom_range(1, 2));
            else if (r < 80)
                idx = '1;
            else
                idx = sva_pkg::INDEX_W'($urandom());
            r = $urandom_range(99);
            if (r < 5)
                val = '0;
            else if (r < 10)
                val = '1;
            else
                val = sva_pkg::VALUE_W'($urandom());
            r = $urandom_range(99);
            if (r < 60)
                sid = sva_pkg::SNAP_ID_W'($urandom_range(model_snap));
            else if (r < 80)
                sid = model_snap + sva_pkg::SNAP_ID_W'($urandom_range(3));
            else
                sid = sva_pkg::SNAP_ID_W'($urandom());
            send_word(op, idx, val, sid);
        end
        settle();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req_bus.valid   = 1'b0;
        req_bus.func    = sva_pkg::FUNC_SET;
        req_bus.index   = '0;
        req_bus.value   = '0;
        req_bus.snap_id = '0;
        foreach (hist_count[i])
            hist_count[i] = 0;
        model_snap = '0;
        length_reg = sva_pkg::LEN_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_length_limits();
        test_history_full();
        test_random_traffic(230, 16, 60, 11'd1024);
        test_random_traffic(230, 60, 16, 11'd2047);
        test_random_traffic(230, 0, 0, 11'd37);

        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && awaited_answers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
